### src/cfp_pkg.sv
// types, constants and codes shared by the csv field parser
package cfp_pkg;

	localparam int unsigned MAX_LINE_BYTES = 1024;
	localparam int unsigned LEN_W = $clog2(MAX_LINE_BYTES);
	localparam int unsigned FIELD_W = 10;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	localparam logic [7:0] DELIM_RESET = 8'd44;
	localparam logic [7:0] QUOTE_RESET = 8'd34;
	localparam logic [7:0] NUL_BYTE = 8'd0;

	localparam logic CFG_DELIMITER = 1'b0;
	localparam logic CFG_QUOTE = 1'b1;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_EOL_IN_QUOTES = 2'd1;
	localparam logic [1:0] ERR_BAD_AFTER_QUOTE = 2'd2;
	localparam logic [1:0] ERR_LINE_TOO_LONG = 2'd3;

	typedef enum logic [2:0] {
		MODE_START,
		MODE_PLAIN,
		MODE_QUOTED,
		MODE_AFTERQ,
		MODE_SKIP
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic end_of_line;
	} csv_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic is_data;
		logic field_end;
		logic field_null;
		logic line_end;
		logic [FIELD_W-1:0] field_number;
		logic [1:0] error_code;
	} csv_out_t;

endpackage

### src/csv_field_parser.sv
// csv field parser: splits lines into delimiter-separated, optionally quoted fields
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_data  (cfp_pkg::csv_in_t)
//  out      output     out_valid/out_ready  out_data (cfp_pkg::csv_out_t)
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// one word per cycle sustained while out_ready keeps the result register free; a word
// passes from the input register through the mode machine into the result register
// the result register lets a new word enter while a result waits to be taken
// reset returns the delimiter to comma, the quote to double quote and starts a
// new line; a word that gives no result never waits on out_ready
module csv_field_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cfp_pkg::csv_in_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cfp_pkg::csv_out_t   out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	logic [7:0] delim_q;
	logic [7:0] quote_q;

	logic valid_s1;
	cfp_pkg::csv_in_t item_s1;

	cfp_pkg::parse_mode_t mode_q, mode_d;
	logic has_bytes_q, has_bytes_d;
	logic [cfp_pkg::FIELD_W-1:0] field_q, field_d;
	logic [cfp_pkg::LEN_W-1:0] len_q, len_d;

	logic has_res;
	cfp_pkg::csv_out_t res;
	logic advance;
	logic eol;
	logic too_long;
	logic [cfp_pkg::FIELD_W-1:0] field_next;

	logic out_valid_q;
	cfp_pkg::csv_out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= cfp_pkg::DELIM_RESET;
			quote_q <= cfp_pkg::QUOTE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cfp_pkg::CFG_DELIMITER: delim_q <= cfg_data;
				cfp_pkg::CFG_QUOTE: quote_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage moves on when its word needs no result slot or the slot frees
	assign advance = valid_s1 && (!has_res || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cfp_pkg::MODE_START;
			has_bytes_q <= 1'b0;
			field_q <= '0;
			len_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			has_bytes_q <= has_bytes_d;
			field_q <= field_d;
			len_q <= len_d;
		end
	end

	assign eol = item_s1.end_of_line || (item_s1.in_byte == cfp_pkg::NUL_BYTE);
	assign too_long = len_q >= cfp_pkg::LEN_W'(cfp_pkg::MAX_LINE_BYTES - 1);
	assign field_next = (field_q == cfp_pkg::FIELD_MAX) ? field_q : field_q + 1'b1;

	always_comb begin
		mode_d = mode_q;
		has_bytes_d = has_bytes_q;
		field_d = field_q;
		len_d = len_q;
		has_res = 1'b0;
		res = '0;
		res.field_number = field_q;

		if (eol) begin
			case (mode_q)
				cfp_pkg::MODE_START: begin
					has_res = 1'b1;
					res.field_end = 1'b1;
					res.field_null = 1'b1;
					res.line_end = 1'b1;
				end
				cfp_pkg::MODE_PLAIN: begin
					has_res = 1'b1;
					res.field_end = 1'b1;
					res.field_null = !has_bytes_q;
					res.line_end = 1'b1;
				end
				cfp_pkg::MODE_QUOTED: begin
					has_res = 1'b1;
					res.error_code = cfp_pkg::ERR_EOL_IN_QUOTES;
				end
				cfp_pkg::MODE_AFTERQ: begin
					has_res = 1'b1;
					res.field_end = 1'b1;
					res.line_end = 1'b1;
				end
				default: ;
			endcase
			mode_d = cfp_pkg::MODE_START;
			has_bytes_d = 1'b0;
			field_d = '0;
			len_d = '0;
		end else if (mode_q == cfp_pkg::MODE_SKIP) begin
			mode_d = cfp_pkg::MODE_SKIP;
		end else if (too_long) begin
			has_res = 1'b1;
			res.error_code = cfp_pkg::ERR_LINE_TOO_LONG;
			mode_d = cfp_pkg::MODE_SKIP;
		end else begin
			len_d = len_q + 1'b1;
			case (mode_q)
				cfp_pkg::MODE_START: begin
					// quote test first when delimiter and quote are the same byte
					if (item_s1.in_byte == quote_q) begin
						mode_d = cfp_pkg::MODE_QUOTED;
					end else if (item_s1.in_byte == delim_q) begin
						has_res = 1'b1;
						res.field_end = 1'b1;
						res.field_null = 1'b1;
						field_d = field_next;
						has_bytes_d = 1'b0;
						mode_d = cfp_pkg::MODE_START;
					end else begin
						has_res = 1'b1;
						res.data_byte = item_s1.in_byte;
						res.is_data = 1'b1;
						has_bytes_d = 1'b1;
						mode_d = cfp_pkg::MODE_PLAIN;
					end
				end
				cfp_pkg::MODE_PLAIN: begin
					has_res = 1'b1;
					if (item_s1.in_byte == delim_q) begin
						res.field_end = 1'b1;
						res.field_null = !has_bytes_q;
						field_d = field_next;
						has_bytes_d = 1'b0;
						mode_d = cfp_pkg::MODE_START;
					end else begin
						res.data_byte = item_s1.in_byte;
						res.is_data = 1'b1;
						has_bytes_d = 1'b1;
					end
				end
				cfp_pkg::MODE_QUOTED: begin
					if (item_s1.in_byte == quote_q) begin
						mode_d = cfp_pkg::MODE_AFTERQ;
					end else begin
						has_res = 1'b1;
						res.data_byte = item_s1.in_byte;
						res.is_data = 1'b1;
					end
				end
				default: begin
					// after a quote inside a quoted field
					has_res = 1'b1;
					if (item_s1.in_byte == quote_q) begin
						res.data_byte = item_s1.in_byte;
						res.is_data = 1'b1;
						mode_d = cfp_pkg::MODE_QUOTED;
					end else if (item_s1.in_byte == delim_q) begin
						res.field_end = 1'b1;
						field_d = field_next;
						has_bytes_d = 1'b0;
						mode_d = cfp_pkg::MODE_START;
					end else begin
						res.error_code = cfp_pkg::ERR_BAD_AFTER_QUOTE;
						mode_d = cfp_pkg::MODE_SKIP;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
